// File: rtl/tcha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and helper functions for the tilt-compensated heading block.
// Used by tcha_mul, tcha_cordic and tilt_compensated_heading_average. No dependencies.
package tcha_pkg;

  localparam int AVG_COUNT_DEF    = 8;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int STEP_MAX         = 24;

  // Datapath width of the CORDIC and gain correction (covers the growth of Q.8 mag values).
  localparam int DW  = 34;
  // Width of a turn-fraction angle (2^32 = full turn).
  localparam int ZW  = 32;
  // Width of the second multiplier operand.
  localparam int BW  = 32;
  localparam int PW  = DW + BW;
  // Accumulator width for one soft-iron matrix row.
  localparam int AW  = 36;
  localparam int REG_W = 48;

  localparam logic [BW-1:0] INV_GAIN = 32'd652032875;
  localparam int GAIN_SHIFT = 30;

  // Configuration register indexes.
  localparam logic [1:0] REG_HARD_IRON = 2'd0;
  localparam logic [1:0] REG_SOFT_X    = 2'd1;
  localparam logic [1:0] REG_SOFT_Y    = 2'd2;
  localparam logic [1:0] REG_SOFT_Z    = 2'd3;

  localparam logic [REG_W-1:0] HARD_IRON_RST = 48'd0;
  localparam logic [REG_W-1:0] SOFT_X_RST    = 48'd16384;
  localparam logic [REG_W-1:0] SOFT_Y_RST    = 48'd1073741824;
  localparam logic [REG_W-1:0] SOFT_Z_RST    = 48'd70368744177664;

  typedef enum logic {
    CORDIC_VEC = 1'b0,
    CORDIC_ROT = 1'b1
  } cordic_mode_e;

  typedef struct packed {
    logic         start;
    cordic_mode_e mode;
  } cordic_req_t;

  function automatic logic [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic [ZW-1:0] r;
    case (idx)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10680862;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41721;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Turn fraction to 16-bit binary angle, rounded.
  function automatic logic [15:0] to_bin16(input logic [ZW-1:0] a);
    logic [ZW-1:0] t;
    t = a + 32'h0000_8000;
    return t[31:16];
  endfunction

endpackage
`default_nettype wire

// File: rtl/tcha_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared signed multiplier with a registered product.
// Depends on tcha_pkg.
module tcha_mul import tcha_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic signed [DW-1:0] a_i,
  input  wire logic signed [BW-1:0] b_i,
  output logic signed [PW-1:0]      p_o
);

  logic signed [PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PW'(a_i) * PW'(b_i);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// File: rtl/tcha_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on tcha_pkg for widths, the arctangent table and the request struct.
module tcha_cordic import tcha_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cordic_req_t          req_i,
  input  wire logic signed [DW-1:0] x_i,
  input  wire logic signed [DW-1:0] y_i,
  input  wire logic [ZW-1:0]        z_i,
  output logic signed [DW-1:0]      x_o,
  output logic signed [DW-1:0]      y_o,
  output logic [ZW-1:0]             z_o,
  output logic                      done_o
);

  localparam int N = (CORDIC_STEPS > STEP_MAX) ? STEP_MAX : CORDIC_STEPS;
  localparam logic [4:0] LAST = 5'(N - 1);

  logic signed [DW-1:0] x_q, x_d, y_q, y_d;
  logic [ZW-1:0]        z_q, z_d;
  logic [4:0]           i_q, i_d;
  logic                 run_q, run_d, done_q, done_d;
  cordic_mode_e         mode_q, mode_d;

  logic signed [DW-1:0] dx, dy;
  logic [ZW-1:0]        ang;
  logic                 up;

  assign dx  = y_q >>> i_q;
  assign dy  = x_q >>> i_q;
  assign ang = atan_entry(i_q);
  // up: x += y>>i, y -= x>>i, z += atan
  assign up  = (mode_q == CORDIC_VEC) ? !y_q[DW-1] : z_q[ZW-1];

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    i_d    = i_q;
    run_d  = run_q;
    done_d = 1'b0;
    mode_d = mode_q;
    if (req_i.start) begin
      mode_d = req_i.mode;
      i_d    = 5'd0;
      run_d  = 1'b1;
      x_d    = x_i;
      y_d    = y_i;
      if (req_i.mode == CORDIC_VEC) begin
        z_d = '0;
        if (x_i == '0 && y_i == '0) begin
          run_d  = 1'b0;
          done_d = 1'b1;
        end else if (x_i[DW-1]) begin
          x_d = -x_i;
          y_d = -y_i;
          z_d = 32'h8000_0000;
        end
      end else begin
        z_d = z_i;
        // fold angles beyond a quarter turn into range
        if ($signed(z_i) > 32'sd1073741824 || $signed(z_i) < -32'sd1073741824) begin
          x_d = -x_i;
          y_d = -y_i;
          z_d = z_i ^ 32'h8000_0000;
        end
      end
    end else if (run_q) begin
      if (up) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + ang;
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - ang;
      end
      i_d = i_q + 5'd1;
      if (i_q == LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
      mode_q <= CORDIC_VEC;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      i_q    <= i_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// File: rtl/tilt_compensated_heading_average.sv
`timescale 1ns / 1ps
`default_nettype none
// Tilt-compensated compass heading with window mean. One sample at a time, not ready meanwhile:
// Per sample: accept, nine matrix products on the shared multiplier (S_MUL, S_ACC each), five CORDIC
// passes of N = min(CORDIC_STEPS, 24) micro-rotations each, and six gain-fix states.
// Zero accel y and z skip the pitch pass; a zero vector ends its pass without micro-rotations.
// Last sample of a window adds the mean (S_DIV, S_EMIT), held while the previous result waits.
// Async active-low reset clears control, window count and heading sum; config takes its defaults.
module tilt_compensated_heading_average import tcha_pkg::*; #(
  parameter int AVG_COUNT    = AVG_COUNT_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z (16 bits each, lowest first)
  input  wire logic [95:0]       s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // roll_angle, pitch_angle, heading_mean, last_accel_x, last_accel_y, last_accel_z
  output logic [95:0]            m_axis_tdata,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_addr_i,
  input  wire logic [REG_W-1:0]  cfg_wdata_i
);

  localparam int CLG   = $clog2(AVG_COUNT);
  localparam int OFF_W = 16 + CLG;
  localparam int SUM_W = OFF_W + 1;
  localparam int CW    = $clog2(AVG_COUNT + 1);
  localparam int SH    = OFF_W + CLG;
  localparam logic [CW-1:0]    AVG_M1   = CW'(AVG_COUNT - 1);
  localparam logic [SUM_W-1:0] OFF_BIAS = SUM_W'(32768 * AVG_COUNT);
  // ceil(2^SH / AVG_COUNT): exact floor quotient for any offset sum below 2^OFF_W
  localparam logic [BW-1:0]    RECIP    = BW'((2**SH + AVG_COUNT - 1) / AVG_COUNT);

  typedef enum logic [21:0] {
    S_IDLE      = 22'h000001,
    S_MUL       = 22'h000002,
    S_ACC       = 22'h000004,
    S_ROLL_GO   = 22'h000008,
    S_ROLL_WAIT = 22'h000010,
    S_GMAG      = 22'h000020,
    S_PITCH_GO  = 22'h000040,
    S_PITCH_WT  = 22'h000080,
    S_ROT1_GO   = 22'h000100,
    S_ROT1_WAIT = 22'h000200,
    S_G1X       = 22'h000400,
    S_G1Y       = 22'h000800,
    S_G1W       = 22'h001000,
    S_ROT2_GO   = 22'h002000,
    S_ROT2_WAIT = 22'h004000,
    S_G2        = 22'h008000,
    S_G2W       = 22'h010000,
    S_HEAD_GO   = 22'h020000,
    S_HEAD_WAIT = 22'h040000,
    S_DIV       = 22'h080000,
    S_EMIT      = 22'h100000,
    S_SPARE     = 22'h200000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [REG_W-1:0] hard_q;
  logic [REG_W-1:0] row_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hard_q   <= HARD_IRON_RST;
      row_q[0] <= SOFT_X_RST;
      row_q[1] <= SOFT_Y_RST;
      row_q[2] <= SOFT_Z_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_HARD_IRON: hard_q   <= cfg_wdata_i;
        REG_SOFT_X:    row_q[0] <= cfg_wdata_i;
        REG_SOFT_Y:    row_q[1] <= cfg_wdata_i;
        REG_SOFT_Z:    row_q[2] <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // sample payload
  logic signed [15:0]   ax_q, ay_q, az_q;
  logic signed [16:0]   raw_q [3];
  logic signed [DW-1:0] m_q [3];
  logic signed [AW-1:0] acc_q, acc_d;
  logic [1:0]           j_q, j_d, k_q, k_d;
  logic [ZW-1:0]        roll_q, pitch_q;
  logic signed [DW-1:0] u_q, v_q, a_q;

  // window state
  logic [CW-1:0]        cnt_q, cnt_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [OFF_W-1:0]     div_q, div_d;

  logic                 out_valid_q, out_valid_d;
  logic [95:0]          out_data_q, out_data_d;

  // shared units
  logic signed [DW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [DW-1:0] gfix;
  cordic_req_t          creq;
  logic signed [DW-1:0] cx_i, cy_i, cx_o, cy_o;
  logic [ZW-1:0]        cz_i, cz_o;
  logic                 cdone;

  tcha_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  tcha_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .x_i    (cx_i),
    .y_i    (cy_i),
    .z_i    (cz_i),
    .x_o    (cx_o),
    .y_o    (cy_o),
    .z_o    (cz_o),
    .done_o (cdone)
  );

  // gain correction: floor(v * INV_GAIN / 2^30)
  assign gfix = prod[GAIN_SHIFT+DW-1:GAIN_SHIFT];

  logic [REG_W-1:0]     row_sel;
  logic signed [15:0]   lane_sel;
  logic signed [16:0]   raw_sel;
  logic signed [AW-1:0] acc_sum;
  logic signed [AW-1:0] prod_t;
  logic [15:0]          head16;
  logic [15:0]          quot;
  logic signed [16:0]   nax;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    row_sel  = row_q[j_q];
    case (k_q)
      2'd0:    lane_sel = row_sel[15:0];
      2'd1:    lane_sel = row_sel[31:16];
      default: lane_sel = row_sel[47:32];
    endcase
    case (k_q)
      2'd0:    raw_sel = raw_q[0];
      2'd1:    raw_sel = raw_q[1];
      default: raw_sel = raw_q[2];
    endcase
    prod_t   = prod[AW-1:0];
    acc_sum  = acc_q + prod_t;
    head16   = to_bin16(cz_o);
    quot     = prod[SH +: 16];
    nax      = -{ax_q[15], ax_q};

    mul_a = DW'(cx_o);
    mul_b = $signed(INV_GAIN);
    if (state_q == S_MUL) begin
      mul_a = DW'(raw_sel);
      mul_b = BW'(lane_sel);
    end else if (state_q == S_G1Y) begin
      mul_a = cy_o;
    end else if (state_q inside {S_DIV, S_EMIT}) begin
      // held through S_EMIT so the quotient stays valid while the output waits
      mul_a = DW'(div_q);
      mul_b = $signed(RECIP);
    end

    creq.start = 1'b0;
    creq.mode  = CORDIC_VEC;
    cx_i = DW'($signed({az_q, 8'd0}));
    cy_i = DW'($signed({ay_q, 8'd0}));
    cz_i = '0;
    case (state_q)
      S_PITCH_GO: begin
        creq.start = (ay_q != '0) || (az_q != '0);
        cx_i = gfix;
        cy_i = DW'($signed({nax, 8'd0}));
      end
      S_ROT1_GO: begin
        creq.start = 1'b1;
        creq.mode  = CORDIC_ROT;
        cx_i = m_q[2];
        cy_i = m_q[1];
        cz_i = -roll_q;
      end
      S_ROT2_GO: begin
        creq.start = 1'b1;
        creq.mode  = CORDIC_ROT;
        cx_i = m_q[0];
        cy_i = u_q;
        cz_i = -pitch_q;
      end
      S_HEAD_GO: begin
        creq.start = 1'b1;
        cx_i = a_q;
        cy_i = -v_q;
      end
      S_ROLL_GO: creq.start = 1'b1;
      default:   ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    j_d         = j_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    div_d       = div_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_MUL;
          acc_d   = '0;
          j_d     = 2'd0;
          k_d     = 2'd0;
        end
      end
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        if (k_q == 2'd2) begin
          acc_d = '0;
          k_d   = 2'd0;
          j_d   = j_q + 2'd1;
          state_d = (j_q == 2'd2) ? S_ROLL_GO : S_MUL;
        end else begin
          acc_d = acc_sum;
          k_d   = k_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_ROLL_GO:   state_d = S_ROLL_WAIT;
      S_ROLL_WAIT: if (cdone) state_d = S_GMAG;
      S_GMAG:      state_d = S_PITCH_GO;
      S_PITCH_GO:  state_d = ((ay_q != '0) || (az_q != '0)) ? S_PITCH_WT : S_ROT1_GO;
      S_PITCH_WT:  if (cdone) state_d = S_ROT1_GO;
      S_ROT1_GO:   state_d = S_ROT1_WAIT;
      S_ROT1_WAIT: if (cdone) state_d = S_G1X;
      S_G1X:       state_d = S_G1Y;
      S_G1Y:       state_d = S_G1W;
      S_G1W:       state_d = S_ROT2_GO;
      S_ROT2_GO:   state_d = S_ROT2_WAIT;
      S_ROT2_WAIT: if (cdone) state_d = S_G2;
      S_G2:        state_d = S_G2W;
      S_G2W:       state_d = S_HEAD_GO;
      S_HEAD_GO:   state_d = S_HEAD_WAIT;
      S_HEAD_WAIT: begin
        if (cdone) begin
          sum_d = sum_q + SUM_W'($signed(head16));
          if (cnt_q == AVG_M1) begin
            // offset the sum so the division works on a non-negative value
            div_d   = OFF_W'(sum_d + $signed(OFF_BIAS));
            state_d = S_DIV;
          end else begin
            cnt_d   = cnt_q + CW'(1);
            state_d = S_IDLE;
          end
        end
      end
      // reciprocal multiply on the shared multiplier, product ready in S_EMIT
      S_DIV: state_d = S_EMIT;
      S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {az_q, ay_q, ax_q, quot ^ 16'h8000,
                         to_bin16(pitch_q), to_bin16(roll_q)};
          cnt_d   = '0;
          sum_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      j_q         <= j_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    div_q      <= div_d;
    out_data_q <= out_data_d;
    if (state_q == S_IDLE && s_axis_tvalid) begin
      ax_q     <= s_axis_tdata[15:0];
      ay_q     <= s_axis_tdata[31:16];
      az_q     <= s_axis_tdata[47:32];
      raw_q[0] <= {s_axis_tdata[63], s_axis_tdata[63:48]} - {hard_q[15], hard_q[15:0]};
      raw_q[1] <= {s_axis_tdata[79], s_axis_tdata[79:64]} - {hard_q[31], hard_q[31:16]};
      raw_q[2] <= {s_axis_tdata[95], s_axis_tdata[95:80]} - {hard_q[47], hard_q[47:32]};
    end
    if (state_q == S_ACC && k_q == 2'd2) m_q[j_q] <= DW'(acc_sum >>> 6);
    if (state_q == S_ROLL_WAIT && cdone) roll_q <= cz_o;
    if (state_q == S_PITCH_GO) begin
      pitch_q <= ax_q > 16'sd0 ? 32'h4000_0000 : 32'hC000_0000;
    end
    if (state_q == S_PITCH_WT && cdone) pitch_q <= cz_o;
    if (state_q == S_G1Y) u_q <= gfix;
    if (state_q == S_G1W) v_q <= gfix;
    if (state_q == S_G2W) a_q <= gfix;
  end

endmodule
`default_nettype wire
